// ===== src/speck64_128_encrypt_defines.svh =====
// Assertion macros shared by the SPECK64/128 encryption checker.
`ifndef SPECK64_128_ENCRYPT_DEFINES_SVH
`define SPECK64_128_ENCRYPT_DEFINES_SVH

// Clocked property that is switched off while reset is asserted.
`define SP64_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) prop) \
        else $error(msg);

// Clocked property that is also checked while reset is asserted.
`define SP64_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

// ===== src/sp64_pkg.sv =====
// Shared types, constants and helpers for the SPECK64/128 encryption pipeline.
`default_nettype none

package sp64_pkg;

    // Data path geometry.
    localparam int unsigned WORD_W         = 32;
    localparam int unsigned BLOCK_W        = 2 * WORD_W;
    localparam int unsigned ROUND_COUNT_DEF = 27;

    // Round rotation amounts.
    localparam int unsigned ROT_ALPHA = 8;
    localparam int unsigned ROT_BETA  = 29;

    // Configuration port.
    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = BLOCK_W;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KEY_LOW  = 1'b0,
        CFG_KEY_HIGH = 1'b1
    } t_cfg_idx;

    // Full 128-bit key as two configuration registers.
    typedef struct packed {
        logic [BLOCK_W-1:0] high;
        logic [BLOCK_W-1:0] low;
    } t_key;

    // Everything one round stage hands to the next: data words and schedule words.
    typedef struct packed {
        logic [WORD_W-1:0] a;
        logic [WORD_W-1:0] b;
        logic [WORD_W-1:0] rk;
        logic [WORD_W-1:0] q0;
        logic [WORD_W-1:0] q1;
        logic [WORD_W-1:0] q2;
    } t_state;

    // Rotate a word right by a constant amount.
    function automatic logic [WORD_W-1:0] rotr32(input logic [WORD_W-1:0] v,
                                                 input int unsigned n);
        rotr32 = (v >> n) | (v << (WORD_W - n));
    endfunction

endpackage

`default_nettype wire

// ===== src/sp64_plain_if.sv =====
// Valid/ready channel that carries one plaintext block per transaction.
`default_nettype none

interface sp64_plain_if;
    import sp64_pkg::*;

    logic               valid;
    logic               ready;
    logic [BLOCK_W-1:0] plain_block;

    modport source (output valid, output plain_block, input ready);
    modport sink   (input valid, input plain_block, output ready);
endinterface

`default_nettype wire

// ===== src/sp64_cipher_if.sv =====
// Valid/ready channel that carries one ciphertext block per transaction.
`default_nettype none

interface sp64_cipher_if;
    import sp64_pkg::*;

    logic               valid;
    logic               ready;
    logic [BLOCK_W-1:0] cipher_block;

    modport source (output valid, output cipher_block, input ready);
    modport sink   (input valid, input cipher_block, output ready);
endinterface

`default_nettype wire

// ===== src/sp64_key.sv =====
// Key configuration registers written through the plain write port.
`default_nettype none

module sp64_key
    import sp64_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_wdata,
    output t_key                       o_key
);

    t_key r_key;

    // Register writes; the key resets to all zeros.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_KEY_LOW: begin
                    r_key.low <= i_cfg_wdata;
                end
                CFG_KEY_HIGH: begin
                    r_key.high <= i_cfg_wdata;
                end
                default: begin
                    r_key <= r_key;
                end
            endcase
        end
    end

    assign o_key = r_key;

endmodule

`default_nettype wire

// ===== src/sp64_round.sv =====
// One pipeline stage: a single cipher round and a single key schedule round.
`default_nettype none

module sp64_round
    import sp64_pkg::*;
#(
    parameter int unsigned ROUND_IDX = 0
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_en,
    input  wire logic i_vld,
    input  t_state    i_st,
    output logic      o_vld,
    output t_state    o_st
);

    localparam logic [WORD_W-1:0] RoundConst = WORD_W'(ROUND_IDX);

    logic   r_vld;
    t_state r_st;
    t_state n_st;
    logic [WORD_W-1:0] w_nl;

    // Data round and key schedule round run side by side.
    always_comb begin
        n_st.a  = (rotr32(i_st.a, ROT_ALPHA) + i_st.b) ^ i_st.rk;
        n_st.b  = rotr32(i_st.b, ROT_BETA) ^ n_st.a;
        w_nl    = (rotr32(i_st.q0, ROT_ALPHA) + i_st.rk) ^ RoundConst;
        n_st.rk = rotr32(i_st.rk, ROT_BETA) ^ w_nl;
        n_st.q0 = i_st.q1;
        n_st.q1 = i_st.q2;
        n_st.q2 = w_nl;
    end

    // Valid bit follows the stage enable.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    // Payload loads only when the stage advances.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_st <= n_st;
        end
    end

    assign o_vld = r_vld;
    assign o_st  = r_st;

endmodule

`default_nettype wire

// ===== src/speck64_128_encrypt.sv =====
// SPECK64/128 encryption: a fully unrolled pipeline with one round per stage.
//
// Usage:
//   Plaintext blocks enter on i_plain and ciphertext blocks leave on o_cipher;
//   both are valid/ready channels, and a transaction completes on a rising
//   clock edge with valid and ready both high.
//   The 128-bit key is set through i_cfg_we/i_cfg_idx/i_cfg_wdata: index 0 is
//   key words zero and one, index 1 is key words two and three. Write the key
//   only while no block is in flight.
// Timing:
//   A block passes ROUND_COUNT rounds (27 by default), one register stage per
//   round, before it is valid at the output. One block is accepted every
//   cycle unless backpressure holds a full pipeline; each stage holds one data
//   round and one key schedule round, a 32-bit add and XOR on each side.
// Reset:
//   A synchronous active-low reset clears every stage valid bit and the key.
// Backpressure:
//   When o_cipher.ready is low, a stage holds only if it and every later stage
//   are full; others still advance, so i_plain.ready stays high until every stage
//   holds a block. Nothing is lost or repeated.
`default_nettype none

module speck64_128_encrypt
    import sp64_pkg::*;
#(
    parameter int unsigned ROUND_COUNT = ROUND_COUNT_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    sp64_plain_if.sink                 i_plain,
    sp64_cipher_if.source              o_cipher,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    t_key   w_key;
    t_state w_st  [ROUND_COUNT+1];
    logic   w_vld [ROUND_COUNT+1];
    logic   w_en  [ROUND_COUNT+1];

    // Key registers.
    sp64_key u_key (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_wdata(i_cfg_wdata),
        .o_key      (w_key)
    );

    // Stage zero input: the plaintext words and the unexpanded key.
    always_comb begin
        w_st[0].a  = i_plain.plain_block[WORD_W-1:0];
        w_st[0].b  = i_plain.plain_block[BLOCK_W-1:WORD_W];
        w_st[0].rk = w_key.low[WORD_W-1:0];
        w_st[0].q0 = w_key.low[BLOCK_W-1:WORD_W];
        w_st[0].q1 = w_key.high[WORD_W-1:0];
        w_st[0].q2 = w_key.high[BLOCK_W-1:WORD_W];
    end

    assign w_vld[0]             = i_plain.valid;
    assign w_en[ROUND_COUNT]    = o_cipher.ready;
    assign i_plain.ready        = w_en[0];

    // Round stages; a stage advances when it is empty or its successor advances.
    for (genvar g = 0; g < ROUND_COUNT; g++) begin : g_round
        assign w_en[g] = !w_vld[g+1] || w_en[g+1];

        sp64_round #(
            .ROUND_IDX(g)
        ) u_round (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_en   (w_en[g]),
            .i_vld  (w_vld[g]),
            .i_st   (w_st[g]),
            .o_vld  (w_vld[g+1]),
            .o_st   (w_st[g+1])
        );
    end

    // The last stage register is the output register.
    assign o_cipher.valid        = w_vld[ROUND_COUNT];
    assign o_cipher.cipher_block = {w_st[ROUND_COUNT].b, w_st[ROUND_COUNT].a};

endmodule

`default_nettype wire

// ===== src/sp64_checker.sv =====
// Port-level checks for the SPECK64/128 encryption pipeline, bound to the top level.
`default_nettype none
`include "speck64_128_encrypt_defines.svh"

module sp64_checker
    import sp64_pkg::*;
(
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_in_ready,
    input wire logic               i_out_valid,
    input wire logic               i_out_ready,
    input wire logic [BLOCK_W-1:0] i_out_data
);

    // A result on hold stays offered.
    `SP64_ASSERT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> i_out_valid, "output valid dropped while stalled")

    // A result on hold keeps its value.
    `SP64_ASSERT(a_out_stable, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> $stable(i_out_data), "output data changed while stalled")

    // Reset empties the pipeline.
    `SP64_ASSERT_ALWAYS(a_rst_empty, i_clk, !i_rst_n |=> !i_out_valid, "output valid right after reset")

    // An empty output stage means every stage can advance.
    `SP64_ASSERT(a_ready_empty, i_clk, i_rst_n, !i_out_valid |-> i_in_ready, "input stalled with empty output stage")

    // A draining output lets the whole pipeline advance.
    `SP64_ASSERT(a_ready_flow, i_clk, i_rst_n, i_out_ready |-> i_in_ready, "input stalled while output drains")

endmodule

bind speck64_128_encrypt sp64_checker u_sp64_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_in_ready (i_plain.ready),
    .i_out_valid(o_cipher.valid),
    .i_out_ready(o_cipher.ready),
    .i_out_data (o_cipher.cipher_block)
);

`default_nettype wire
